>>> src/ps2_mouse_device_emulator_top_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse device emulator: assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_DEVICE_EMULATOR_TOP_DEFINES_SVH
`define PS2_MOUSE_DEVICE_EMULATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define PS2M_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define PS2M_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PS2M_ASSERT(label, clk, rst, prop, msg)
`define PS2M_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> src/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device emulator package
// Item types, byte codes, register indexes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2m_pkg;

   // input action codes
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_CMD   = 2'd1,
      ACT_EVENT = 2'd2
   } action_type;

   // device modes
   typedef enum logic [1:0] {
      MODE_POWER_ON  = 2'd0,
      MODE_RESETTING = 2'd1,
      MODE_CONFIG    = 2'd2,
      MODE_STREAM    = 2'd3
   } mode_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_ON_WAIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REJECT_WAIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_WAIT    = 2'd2;

   localparam logic [15:0] POWER_ON_WAIT_RESET = 16'd4000;
   localparam logic [15:0] REJECT_WAIT_RESET   = 16'd1000;
   localparam logic [15:0] RESET_WAIT_RESET    = 16'd500;

   // protocol bytes
   localparam logic [7:0] BYTE_ACK       = 8'hfa;
   localparam logic [7:0] BYTE_SELF_TEST = 8'haa;
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_DEV_ID    = 8'h03;
   localparam logic [7:0] BYTE_RATE      = 8'h64;
   localparam logic [7:0] BYTE_PKT_BASE  = 8'h08;
   localparam logic [7:0] CMD_GET_ID     = 8'hf2;
   localparam logic [7:0] CMD_STATUS     = 8'he9;
   localparam logic [7:0] CMD_ENABLE     = 8'hf4;
   localparam logic [7:0] CMD_RESET      = 8'hff;

   // event codes
   localparam logic [15:0] EV_BUTTON  = 16'h0001;
   localparam logic [15:0] EV_REL     = 16'h0002;
   localparam logic [15:0] BTN_LEFT   = 16'h0110;
   localparam logic [15:0] BTN_RIGHT  = 16'h0111;
   localparam logic [15:0] BTN_MIDDLE = 16'h0112;
   localparam logic [15:0] AXIS_X     = 16'h0000;
   localparam logic [15:0] AXIS_Y     = 16'h0001;
   localparam logic [15:0] AXIS_WHEEL = 16'h0008;

   // default run queue depth
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         cmd_byte;
      logic [15:0]        ev_type;
      logic [15:0]        ev_code;
      logic signed [31:0] ev_value;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   // one run of up to four bytes, byte 0 sent first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } run_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

endpackage

`default_nettype wire

>>> src/ps2m_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse front end
// Accepts items, keeps the device mode and timers, and builds byte runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2m_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire ps2m_pkg::req_type                    req_data,
   input  wire logic                                 csr_write_en,
   input  wire logic [ps2m_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ps2m_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire ps2m_pkg::queue_stat_type             q_stat,
   output logic                                      push,
   output ps2m_pkg::run_type                         push_run
);
   import ps2m_pkg::*;

   logic [15:0] power_on_wait_ff;
   logic [15:0] reject_wait_ff;
   logic [15:0] reset_wait_ff;
   mode_type    mode_ff, mode_in;
   logic [15:0] wait_ff, wait_in;
   logic        hot_ff, hot_in;
   logic        left_ff, left_in;
   logic        accept;
   logic        gen;
   run_type     run;
   logic        value_nz;
   logic [7:0]  value_lo;
   mode_type    cmd_mode;

   assign req_ready = ~q_stat.full;
   assign accept    = req_valid & req_ready;
   assign value_nz  = (req_data.ev_value != '0);
   assign value_lo  = req_data.ev_value[7:0];
   // a command in resetting mode is handled as in config
   assign cmd_mode  = (mode_ff == MODE_RESETTING) ? MODE_CONFIG : mode_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_on_wait_ff <= POWER_ON_WAIT_RESET;
         reject_wait_ff   <= REJECT_WAIT_RESET;
         reset_wait_ff    <= RESET_WAIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_POWER_ON_WAIT: power_on_wait_ff <= csr_wdata;
            CSR_REJECT_WAIT:   reject_wait_ff   <= csr_wdata;
            CSR_RESET_WAIT:    reset_wait_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      wait_in = wait_ff;
      hot_in  = hot_ff;
      left_in = left_ff;
      case (req_data.action)
         ACT_TICK: begin
            if (wait_ff != '0) begin
               wait_in = 16'(wait_ff - 16'd1);
            end else if (mode_ff == MODE_POWER_ON) begin
               mode_in = MODE_RESETTING;
               hot_in  = 1'b1;
            end else if (mode_ff == MODE_RESETTING) begin
               mode_in = MODE_CONFIG;
            end
         end
         ACT_CMD: begin
            if (mode_ff == MODE_POWER_ON) begin
               if (req_data.cmd_byte == CMD_RESET) begin
                  mode_in = MODE_RESETTING;
                  hot_in  = 1'b0;
                  wait_in = reset_wait_ff;
               end else begin
                  wait_in = reject_wait_ff;
               end
            end else begin
               mode_in = cmd_mode;
               if (cmd_mode == MODE_CONFIG && req_data.cmd_byte == CMD_ENABLE) begin
                  mode_in = MODE_STREAM;
               end
               if (req_data.cmd_byte == CMD_RESET) begin
                  mode_in = MODE_RESETTING;
                  hot_in  = 1'b0;
                  wait_in = reset_wait_ff;
               end
            end
         end
         ACT_EVENT: begin
            if (mode_ff == MODE_STREAM && req_data.ev_type == EV_BUTTON &&
                req_data.ev_code == BTN_LEFT) begin
               left_in = value_nz;
            end
         end
         default: ;
      endcase
   end

   // build the byte run for this item
   always_comb begin
      gen      = 1'b0;
      run      = '0;
      case (req_data.action)
         ACT_TICK: begin
            if (wait_ff == '0 && mode_ff == MODE_RESETTING) begin
               gen           = 1'b1;
               run.bytes[0]  = BYTE_SELF_TEST;
               run.bytes[1]  = BYTE_ZERO;
               run.last_idx  = hot_ff ? 2'd0 : 2'd1;
            end
         end
         ACT_CMD: begin
            if (mode_ff != MODE_POWER_ON || req_data.cmd_byte == CMD_RESET) begin
               gen          = 1'b1;
               run.bytes[0] = BYTE_ACK;
               if (mode_ff != MODE_POWER_ON && cmd_mode == MODE_CONFIG) begin
                  if (req_data.cmd_byte == CMD_GET_ID) begin
                     run.bytes[1] = BYTE_DEV_ID;
                     run.last_idx = 2'd1;
                  end else if (req_data.cmd_byte == CMD_STATUS) begin
                     run.bytes[1] = BYTE_ZERO;
                     run.bytes[2] = BYTE_ZERO;
                     run.bytes[3] = BYTE_RATE;
                     run.last_idx = 2'd3;
                  end
               end
            end
         end
         ACT_EVENT: begin
            if (mode_ff == MODE_STREAM) begin
               gen          = 1'b1;
               run.last_idx = 2'd3;
               run.bytes[0] = BYTE_PKT_BASE;
               if (req_data.ev_type == EV_BUTTON) begin
                  run.bytes[0][0] = (req_data.ev_code == BTN_LEFT) ? value_nz : left_ff;
                  run.bytes[0][1] = (req_data.ev_code == BTN_RIGHT) && value_nz;
                  run.bytes[0][2] = (req_data.ev_code == BTN_MIDDLE) && value_nz;
               end else if (req_data.ev_type == EV_REL) begin
                  run.bytes[0][0] = left_ff;
                  if (req_data.ev_code == AXIS_X) begin
                     run.bytes[1]    = value_lo;
                     run.bytes[0][4] = value_lo[7];
                  end else if (req_data.ev_code == AXIS_Y) begin
                     run.bytes[2]    = value_lo;
                     run.bytes[0][5] = value_lo[7];
                  end else if (req_data.ev_code == AXIS_WHEEL) begin
                     run.bytes[3] = value_lo;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign push     = accept & gen;
   assign push_run = run;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_POWER_ON;
         wait_ff <= POWER_ON_WAIT_RESET;
         hot_ff  <= 1'b0;
         left_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         wait_ff <= wait_in;
         hot_ff  <= hot_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

>>> src/ps2m_queue.sv
// ----------------------------------------------------------------------------
// PS/2 mouse run queue
// Short FIFO of byte runs between the front end and the byte sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_device_emulator_top_defines.svh"

module ps2m_queue #(
   parameter int QUEUE_DEPTH = ps2m_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ps2m_pkg::run_type         push_run,
   input  wire logic                      pop,
   output ps2m_pkg::run_type              head_run,
   output ps2m_pkg::queue_stat_type       q_stat
);
   import ps2m_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   run_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store runs
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

   assign head_run         = entries_ff[rd_ptr_ff];
   assign q_stat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);

   `PS2M_NEVER(a_no_overflow, clock, reset, push && count_ff == CNT_W'(QUEUE_DEPTH), "run queue overflow")
   `PS2M_NEVER(a_no_underflow, clock, reset, pop && count_ff == '0, "run queue underflow")
   `PS2M_ASSERT(a_count_up, clock, reset, push && !pop |=> count_ff == CNT_W'($past(count_ff) + 1'b1), "queue count did not advance")

endmodule

`default_nettype wire

>>> src/ps2m_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse byte sender
// Takes runs from the queue and hands them out one byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_device_emulator_top_defines.svh"

module ps2m_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ps2m_pkg::queue_stat_type  q_stat,
   input  wire ps2m_pkg::run_type         head_run,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ps2m_pkg::rsp_type              rsp_data
);
   import ps2m_pkg::*;

   run_type    cur_ff;
   logic [1:0] idx_ff;
   logic       valid_ff;
   logic       is_last;

   assign is_last = (idx_ff == cur_ff.last_idx);
   // load the next run when idle or when the last byte leaves
   assign pop     = q_stat.not_empty & (~valid_ff | (rsp_ready & is_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_ready) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= 2'(idx_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_run;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data.tx_byte = cur_ff.bytes[idx_ff];
   assign rsp_data.last    = is_last;

   `PS2M_NEVER(a_idx_in_run, clock, reset, valid_ff && idx_ff > cur_ff.last_idx, "byte index past run end")
   `PS2M_ASSERT(a_step_byte, clock, reset, valid_ff && rsp_ready && !is_last |=> valid_ff && idx_ff == 2'($past(idx_ff) + 2'd1), "byte index did not step")
   `PS2M_ASSERT(a_pop_starts, clock, reset, pop |=> valid_ff && idx_ff == '0, "popped run not started")

endmodule

`default_nettype wire

>>> src/ps2_mouse_device_emulator_top.sv
// A run holds 4 bytes at most; its first byte is offered once the run has passed the
// queue entry and the sender's run register. Items that cause no bytes are taken one
// per cycle while the queue has room; bytes leave one per cycle on rsp_ready.
// The run queue depth sets how far the front end may run ahead of the byte sender.
// Reset (synchronous, active high): registers to 4000/1000/500, power-on mode,
// timer loaded with 4000, run queue and byte sender empty.
// ----------------------------------------------------------------------------
// PS/2 mouse device emulator top level
// Front end, run queue and byte sender of a wheel mouse device side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_device_emulator_top #(
   parameter int QUEUE_DEPTH = ps2m_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ps2m_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ps2m_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_write_en,
   input  wire logic [ps2m_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ps2m_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ps2m_pkg::*;

   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   run_type        push_run;
   run_type        head_run;

   ps2m_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_stat       (q_stat),
      .push         (push),
      .push_run     (push_run)
   );

   ps2m_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head_run (head_run),
      .q_stat   (q_stat)
   );

   ps2m_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_run  (head_run),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> test/tb_ps2_mouse_device_emulator_top.sv
// ----------------------------------------------------------------------------
// PS/2 mouse device emulator testbench
// Drives ticks, host command bytes and pointer events into the device side of
// a wheel mouse. A behavioral copy of the device tracks mode, timer, hot reset
// and left button, and predicts every byte run. Starts with a directed table
// through power-on, reset, config and stream, then runs random traffic under
// three register settings. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ps2_mouse_device_emulator_top;
   import ps2m_pkg::*;

   // action code that the device ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int RANDOM_PER_PHASE = 78;
   localparam int PAUSE_EVERY      = 40;

   typedef struct {
      req_type         item;
      bit              typed;
      int              count;
      logic [3:0][7:0] run;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // device copy: registers and state
   logic [15:0] dev_power_on_wait;
   logic [15:0] dev_reject_wait;
   logic [15:0] dev_reset_wait;
   mode_type    dev_mode;
   logic [15:0] dev_wait;
   logic        dev_hot_reset;
   logic        dev_left_held;

   rsp_type      pending_bytes[$];
   stim_row_type stim_rows[$];
   int           mismatch_count = 0;
   int           bytes_checked  = 0;
   int           directed_items = 0;
   int           random_items   = 0;
   int           burst_left     = 0;
   int           idle_cycles    = 0;

   ps2_mouse_device_emulator_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("[%0t] %s: got %02h, expected %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   // turn a first-to-last literal into a run with byte 0 first
   function automatic logic [3:0][7:0] run_of(input logic [31:0] first_to_last);
      logic [3:0][7:0] run;
      for (int k = 0; k < 4; k++) run[k] = first_to_last[31-8*k -: 8];
      return run;
   endfunction

   function automatic req_type mk_req(input logic [1:0] act, input logic [7:0] cmd,
                                      input logic [15:0] ev_type, input logic [15:0] ev_code,
                                      input logic [31:0] ev_value);
      req_type it;
      it.action   = act;
      it.cmd_byte = cmd;
      it.ev_type  = ev_type;
      it.ev_code  = ev_code;
      it.ev_value = ev_value;
      return it;
   endfunction

   // advance the device copy by one item; return the byte count of its run
   function automatic int mouse_step(input req_type it, output logic [3:0][7:0] run);
      int         n;
      logic [7:0] v;
      n   = 0;
      run = '0;
      v   = it.ev_value[7:0];
      case (it.action)
         ACT_TICK: begin
            if (dev_wait != 16'd0) begin
               dev_wait = dev_wait - 16'd1;
            end else if (dev_mode == MODE_POWER_ON) begin
               dev_mode      = MODE_RESETTING;
               dev_hot_reset = 1'b1;
            end else if (dev_mode == MODE_RESETTING) begin
               run[0]   = BYTE_SELF_TEST;
               run[1]   = BYTE_ZERO;
               n        = dev_hot_reset ? 1 : 2;
               dev_mode = MODE_CONFIG;
            end
         end
         ACT_CMD: begin
            run[0] = BYTE_ACK;
            n      = 1;
            if (dev_mode == MODE_POWER_ON) begin
               if (it.cmd_byte == CMD_RESET) begin
                  dev_hot_reset = 1'b0;
                  dev_wait      = dev_reset_wait;
                  dev_mode      = MODE_RESETTING;
               end else begin
                  dev_wait = dev_reject_wait;
                  n        = 0;
               end
            end else begin
               // a command drops a pending self-test result
               if (dev_mode == MODE_RESETTING) dev_mode = MODE_CONFIG;
               if (dev_mode == MODE_CONFIG) begin
                  if (it.cmd_byte == CMD_GET_ID) begin
                     run[1] = BYTE_DEV_ID;
                     n      = 2;
                  end else if (it.cmd_byte == CMD_STATUS) begin
                     run[1] = BYTE_ZERO;
                     run[2] = BYTE_ZERO;
                     run[3] = BYTE_RATE;
                     n      = 4;
                  end
                  if (it.cmd_byte == CMD_ENABLE) dev_mode = MODE_STREAM;
               end
               if (it.cmd_byte == CMD_RESET) begin
                  dev_hot_reset = 1'b0;
                  dev_wait      = dev_reset_wait;
                  dev_mode      = MODE_RESETTING;
               end
            end
         end
         ACT_EVENT: begin
            if (dev_mode == MODE_STREAM) begin
               n      = 4;
               run[0] = BYTE_PKT_BASE;
               if (it.ev_type == EV_BUTTON) begin
                  if (it.ev_code == BTN_LEFT) begin
                     dev_left_held = (it.ev_value != 0);
                  end else begin
                     if (it.ev_code == BTN_RIGHT && it.ev_value != 0) run[0][1] = 1'b1;
                     if (it.ev_code == BTN_MIDDLE && it.ev_value != 0) run[0][2] = 1'b1;
                  end
                  run[0][0] = dev_left_held;
               end else if (it.ev_type == EV_REL) begin
                  run[0][0] = dev_left_held;
                  if (it.ev_code == AXIS_X) begin
                     run[1]    = v;
                     run[0][4] = v[7];
                  end else if (it.ev_code == AXIS_Y) begin
                     run[2]    = v;
                     run[0][5] = v[7];
                  end else if (it.ev_code == AXIS_WHEEL) begin
                     run[3] = v;
                  end
               end
            end
         end
         default: n = 0;
      endcase
      return n;
   endfunction

   // queue the bytes an accepted item causes; typed rows use their own run
   task automatic take_item(input req_type it, input bit typed, input int typed_count,
                            input logic [3:0][7:0] typed_run);
      logic [3:0][7:0] run;
      int              n;
      rsp_type         r;
      n = mouse_step(it, run);
      if (typed) begin
         n   = typed_count;
         run = typed_run;
      end
      for (int k = 0; k < n; k++) begin
         r.tx_byte = run[k];
         r.last    = (k == n - 1);
         pending_bytes.push_back(r);
      end
   endtask

   // offer one item, with a random gap at the start of each burst
   task automatic send_item(input req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 8);
         gap        = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender until every queued byte has arrived
   task automatic wait_for_results();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csrs(input logic [15:0] boot_wait, input logic [15:0] reject,
                             input logic [15:0] reset_w);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [15:0]            vals [3];
      idx  = '{CSR_POWER_ON_WAIT, CSR_REJECT_WAIT, CSR_RESET_WAIT};
      vals = '{boot_wait, reject, reset_w};
      for (int i = 0; i < 3; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_wdata    <= vals[i];
         @(posedge clock);
      end
      csr_write_en      <= 1'b0;
      dev_power_on_wait = boot_wait;
      dev_reject_wait   = reject;
      dev_reset_wait    = reset_w;
   endtask

   // well-formed pointer event with random content, now and then an odd one
   function automatic req_type rand_event();
      req_type it;
      int      pick;
      it   = mk_req(ACT_EVENT, 8'($urandom), 16'($urandom), 16'($urandom), $urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
         it.ev_type = EV_BUTTON;
         case ($urandom_range(9))
            0, 1, 2: it.ev_code = BTN_LEFT;
            3, 4, 5: it.ev_code = BTN_RIGHT;
            6, 7, 8: it.ev_code = BTN_MIDDLE;
            default: ;
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3: it.ev_value = 0;
            4, 5, 6: it.ev_value = 1;
            default: ;
         endcase
      end else if (pick < 95) begin
         it.ev_type = EV_REL;
         case ($urandom_range(9))
            0, 1, 2: it.ev_code = AXIS_X;
            3, 4, 5: it.ev_code = AXIS_Y;
            6, 7, 8: it.ev_code = AXIS_WHEEL;
            default: ;
         endcase
         if ($urandom_range(2) != 0) it.ev_value = int'($urandom_range(255)) - 128;
      end
      return it;
   endfunction

   // pick the next random item from the current device mode
   function automatic req_type next_item();
      req_type it;
      int      pick;
      it   = mk_req(ACT_CMD, 8'($urandom), 16'($urandom), 16'($urandom), $urandom);
      pick = $urandom_range(99);
      case (dev_mode)
         MODE_STREAM: begin
            if (pick < 75) it = rand_event();
            else if (pick < 85) it.action = ACT_TICK;
            else if (pick < 93) it.action = ACT_CMD;
            else if (pick < 95) it.cmd_byte = CMD_RESET;
            else if (pick < 97) it.action = ACT_UNUSED;
            else it.action = ACT_EVENT;
         end
         MODE_CONFIG: begin
            if (pick < 40) it.cmd_byte = CMD_ENABLE;
            else if (pick < 55) it.cmd_byte = CMD_GET_ID;
            else if (pick < 65) it.cmd_byte = CMD_STATUS;
            else if (pick < 70) it.cmd_byte = CMD_RESET;
            else if (pick < 85) it.action = ACT_CMD;
            else if (pick < 93) it.action = ACT_TICK;
            else it = rand_event();
         end
         MODE_RESETTING: begin
            if (dev_wait <= 16'd8) begin
               if (pick < 85) it.action = ACT_TICK;
            end else begin
               if (pick < 50) it.cmd_byte = CMD_ENABLE;
               else if (pick < 75) it.action = ACT_CMD;
               else if (pick < 90) it.action = ACT_TICK;
               else it = rand_event();
            end
         end
         default: if (pick < 50) it.action = ACT_TICK;
      endcase
      return it;
   endfunction

   task automatic random_phase();
      req_type it;
      bit      ignored;
      int      counted;
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
         it      = next_item();
         ignored = (it.action == ACT_UNUSED) ||
                   (it.action == ACT_EVENT && dev_mode != MODE_STREAM);
         send_item(it);
         take_item(it, 1'b0, 0, '0);
         random_items++;
         if (!ignored) begin
            counted++;
            if (counted % PAUSE_EVERY == 0) wait_for_results();
         end
      end
   endtask

   task automatic add_row(input req_type it, input bit typed, input int count,
                          input logic [31:0] first_to_last);
      stim_row_type row;
      row.item  = it;
      row.typed = typed;
      row.count = count;
      row.run   = run_of(first_to_last);
      stim_rows.push_back(row);
   endtask

   // receiver: stall in one of four styles, picked at random
   int rx_cycle = 0;
   int rx_style = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 100 == 0) rx_style <= $urandom_range(3);
      case (rx_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= (rx_cycle % 4 != 3);
         2: rsp_ready <= 1'($urandom_range(1));
         default: rsp_ready <= (rx_cycle % 5 == 0);
      endcase
   end

   // compare each delivered byte with the oldest queued one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected byte", rsp_data.tx_byte, 8'h00);
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_data.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", rsp_data.tx_byte, want.tx_byte);
            if (rsp_data.last !== want.last)
               report_mismatch("last", {7'd0, rsp_data.last}, {7'd0, want.last});
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
         $display("ps2_mouse_device_emulator_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit       pick_reset;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      dev_power_on_wait = POWER_ON_WAIT_RESET;
      dev_reject_wait   = REJECT_WAIT_RESET;
      dev_reset_wait    = RESET_WAIT_RESET;
      dev_mode          = MODE_POWER_ON;
      dev_wait          = POWER_ON_WAIT_RESET;
      dev_hot_reset     = 1'b0;
      dev_left_held     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // short waits so the directed walk leaves power-on quickly
      write_csrs(16'd0, 16'd1, 16'd2);

      // power-on: either a reset command or a rejected byte and a hot reset
      pick_reset = 1'($urandom_range(1));
      add_row(mk_req(ACT_TICK, 8'h00, 16'h0, 16'h0, 32'h0), 1'b1, 0, 32'h0);
      add_row(mk_req(ACT_CMD, pick_reset ? CMD_RESET : 8'h00, 16'h0, 16'h0, 32'h0),
              1'b0, 0, 32'h0);
      repeat (3) add_row(mk_req(ACT_TICK, 8'h00, 16'h0, 16'h0, 32'h0), 1'b0, 0, 32'h0);
      // config commands
      add_row(mk_req(ACT_CMD, CMD_GET_ID, 16'h0, 16'h0, 32'h0), 1'b1, 2, 32'hfa030000);
      add_row(mk_req(ACT_CMD, CMD_STATUS, 16'h0, 16'h0, 32'h0), 1'b1, 4, 32'hfa000064);
      add_row(mk_req(ACT_CMD, 8'h00, 16'h0, 16'h0, 32'h0), 1'b1, 1, 32'hfa000000);
      add_row(mk_req(ACT_CMD, CMD_RESET, 16'h0, 16'h0, 32'h0), 1'b1, 1, 32'hfa000000);
      // event while resetting is dropped; reset wait ends in AA 00
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, AXIS_X, 32'h5), 1'b1, 0, 32'h0);
      repeat (2) add_row(mk_req(ACT_TICK, 8'h00, 16'h0, 16'h0, 32'h0), 1'b1, 0, 32'h0);
      add_row(mk_req(ACT_TICK, 8'h00, 16'h0, 16'h0, 32'h0), 1'b1, 2, 32'haa000000);
      // command while resetting drops the self-test and enables streaming
      add_row(mk_req(ACT_CMD, CMD_RESET, 16'h0, 16'h0, 32'h0), 1'b1, 1, 32'hfa000000);
      add_row(mk_req(ACT_CMD, CMD_ENABLE, 16'h0, 16'h0, 32'h0), 1'b1, 1, 32'hfa000000);
      add_row(mk_req(ACT_UNUSED, 8'hff, 16'hffff, 16'hffff, 32'hffffffff), 1'b1, 0, 32'h0);
      // stream packets: buttons, axes, sign bits, odd types and axes
      add_row(mk_req(ACT_EVENT, 8'h00, EV_BUTTON, BTN_LEFT, 32'h1), 1'b1, 4, 32'h09000000);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, AXIS_X, 32'h80), 1'b1, 4, 32'h19800000);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, AXIS_Y, 32'h8000007f), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, AXIS_Y, 32'hffffff80), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, AXIS_WHEEL, 32'h7fffffff), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_BUTTON, BTN_RIGHT, 32'h80000000), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_BUTTON, BTN_MIDDLE, 32'hffffffff), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_BUTTON, BTN_LEFT, 32'h0), 1'b0, 0, 32'h0);
      add_row(mk_req(ACT_EVENT, 8'h00, 16'hffff, 16'hffff, 32'h7f), 1'b1, 4, 32'h08000000);
      add_row(mk_req(ACT_EVENT, 8'h00, EV_REL, 16'h0005, 32'hffffffff),
              1'b1, 4, 32'h08000000);
      add_row(mk_req(ACT_CMD, CMD_GET_ID, 16'h0, 16'h0, 32'h0), 1'b1, 1, 32'hfa000000);

      foreach (stim_rows[i]) begin
         send_item(stim_rows[i].item);
         take_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].count,
                   stim_rows[i].run);
         directed_items++;
      end

      // random traffic under extreme and ordinary register settings
      drain();
      write_csrs(16'hffff, 16'hffff, 16'd0);
      random_phase();
      drain();
      write_csrs(16'd0, 16'd0, 16'hffff);
      random_phase();
      drain();
      write_csrs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 6)));
      random_phase();
      drain();

      if (pending_bytes.size() != 0)
         report_mismatch("bytes never delivered", 8'(pending_bytes.size()), 8'h00);

      $display("Run covered %0d directed and %0d random items, %0d bytes checked,",
               directed_items, random_items, bytes_checked);
      $display("through power-on, reset wait, config and stream under 4 register settings.");
      if (mismatch_count == 0) begin
         $display("ps2_mouse_device_emulator_top: match");
      end else begin
         $display("ps2_mouse_device_emulator_top: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/ps2m_pkg.sv
src/ps2m_front.sv
src/ps2m_queue.sv
src/ps2m_back.sv
src/ps2_mouse_device_emulator_top.sv
test/tb_ps2_mouse_device_emulator_top.sv
